>>> hw/rtl/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

    localparam int FRAC_W  = 16;
    localparam int LEVEL_W = 17;
    localparam int MULT_W  = 14;
    localparam int PROD_W  = FRAC_W + MULT_W;
    localparam int PIPE_DEPTH = 6;

    localparam logic [16:0] Q_ONE       = 17'd65536;
    localparam logic [15:0] Q_THIRD     = 16'd21845;
    localparam logic [15:0] Q_SIXTH     = 16'd10923;
    localparam logic [15:0] Q_HALF      = 16'd32768;
    localparam logic [15:0] Q_TWOTHIRDS = 16'd43691;
    localparam logic [23:0] OUT_SCALE   = 24'd16705126;

    localparam logic [1:0] REG_RISE = 2'd0;
    localparam logic [1:0] REG_TOP  = 2'd1;
    localparam logic [1:0] REG_FALL = 2'd2;
    localparam logic [1:0] REG_BASE = 2'd3;

    typedef struct packed {
        logic [FRAC_W-1:0] lo;
        logic [FRAC_W-1:0] hi;
        logic [FRAC_W-1:0] diff;
    } levels_t;

    typedef struct packed {
        logic       vld;
        logic       grey;
        logic [7:0] level;
    } grey_tap_t;

endpackage

`default_nettype wire

>>> hw/rtl/hsl_to_rgb_converter.sv
// Channel | Ports                                        | Direction
// s_      | s_valid s_ready s_hue s_saturation s_lightness | pixel in
// m_      | m_valid m_ready m_red m_green m_blue         | pixel out
//
// One pixel per cycle while the output is not stalled.
// Six register stages: helper levels, hue classify, ramp multiply, ramp add,
// scale multiply, clip and grey select.
// aresetn (synchronous) clears the stage valid bits only.
// A stalled output holds the whole pipeline; s_ready follows that enable.
`default_nettype none

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_hue,
    input  wire logic [7:0] s_saturation,
    input  wire logic [7:0] s_lightness,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue
);

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  grey_reg [PIPE_DEPTH-1];
    logic [7:0]            lgt_reg  [PIPE_DEPTH-1];
    logic                  en;
    logic [FRAC_W-1:0]     fh;
    logic [16:0]           r_sum;
    logic [FRAC_W-1:0]     pos_red;
    logic [FRAC_W-1:0]     pos_blue;
    levels_t               levels;
    grey_tap_t             tap;

    assign en      = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grey_reg[0] <= (s_saturation == 8'd0);
            lgt_reg[0]  <= s_lightness;
            for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
                grey_reg[i] <= grey_reg[i-1];
                lgt_reg[i]  <= lgt_reg[i-1];
            end
        end
    end

    always_comb begin
        fh    = {s_hue, 8'b0};
        r_sum = 17'(fh) + 17'(Q_THIRD);
        if (r_sum > Q_ONE) begin
            pos_red = 16'(r_sum - Q_ONE);
        end else begin
            pos_red = r_sum[15:0];
        end
        if (fh < Q_THIRD) begin
            pos_blue = 16'(17'(fh) + Q_ONE - 17'(Q_THIRD));
        end else begin
            pos_blue = fh - Q_THIRD;
        end
    end

    assign tap.vld   = vld_reg[PIPE_DEPTH-2];
    assign tap.grey  = grey_reg[PIPE_DEPTH-2];
    assign tap.level = lgt_reg[PIPE_DEPTH-2];

    hsl2rgb_levels u_levels (
        .aclk         (aclk),
        .en_i         (en),
        .saturation_i (s_saturation),
        .lightness_i  (s_lightness),
        .levels_o     (levels)
    );

    hsl2rgb_channel u_red (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en_i     (en),
        .pos_i    (pos_red),
        .levels_i (levels),
        .tap_i    (tap),
        .byte_o   (m_red)
    );

    hsl2rgb_channel u_green (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en_i     (en),
        .pos_i    (fh),
        .levels_i (levels),
        .tap_i    (tap),
        .byte_o   (m_green)
    );

    hsl2rgb_channel u_blue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en_i     (en),
        .pos_i    (pos_blue),
        .levels_i (levels),
        .tap_i    (tap),
        .byte_o   (m_blue)
    );

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

>>> hw/rtl/hsl2rgb_levels.sv
`default_nettype none

module hsl2rgb_levels
    import hsl2rgb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       en_i,
    input  wire logic [7:0] saturation_i,
    input  wire logic [7:0] lightness_i,
    output levels_t         levels_o
);

    logic [15:0]       ls_reg;
    logic [7:0]        s_reg;
    logic [7:0]        l_reg;
    levels_t           lv_reg;

    logic [15:0]       fl;
    logic [15:0]       fs;
    logic [16:0]       t2_wide;
    logic [FRAC_W-1:0] t2;
    logic [16:0]       fl2;
    logic [FRAC_W-1:0] t1_raw;
    logic [FRAC_W-1:0] t1;
    levels_t           lv_next;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            ls_reg <= 16'(saturation_i) * 16'(lightness_i);
            s_reg  <= saturation_i;
            l_reg  <= lightness_i;
            lv_reg <= lv_next;
        end
    end

    always_comb begin
        fl = {l_reg, 8'b0};
        fs = {s_reg, 8'b0};
        if (!l_reg[7]) begin
            t2_wide = 17'(fl) + 17'(ls_reg);
        end else begin
            t2_wide = 17'(fl) + 17'(fs) - 17'(ls_reg);
        end
        t2  = t2_wide[15:0];
        fl2 = {fl, 1'b0};
        if (fl2 < 17'(t2)) begin
            t1_raw = '0;
        end else begin
            t1_raw = 16'(fl2 - 17'(t2));
        end
        t1 = (t1_raw > t2) ? t2 : t1_raw;
        lv_next.lo   = t1;
        lv_next.hi   = t2;
        lv_next.diff = t2 - t1;
    end

    assign levels_o = lv_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hsl2rgb_channel.sv
`default_nettype none

module hsl2rgb_channel
    import hsl2rgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en_i,
    input  wire logic [FRAC_W-1:0] pos_i,
    input  wire levels_t           levels_i,
    input  wire grey_tap_t         tap_i,
    output logic [7:0]             byte_o
);

    logic [1:0]         reg1_reg;
    logic [MULT_W-1:0]  mult1_reg;
    logic [1:0]         reg2_reg;
    logic [MULT_W-1:0]  mult2_reg;
    logic [1:0]         reg3_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [FRAC_W-1:0]  lo_reg;
    logic [FRAC_W-1:0]  hi_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [8:0]         scaled_reg;
    logic [7:0]         byte_reg;

    logic [1:0]         reg1_next;
    logic [MULT_W-1:0]  mult1_next;
    logic [32:0]        prod6;
    logic [LEVEL_W-1:0] level_next;
    logic [40:0]        scaled_full;
    logic [7:0]         byte_next;

    always_comb begin
        if (pos_i < Q_SIXTH) begin
            reg1_next  = REG_RISE;
            mult1_next = pos_i[MULT_W-1:0];
        end else if (pos_i < Q_HALF) begin
            reg1_next  = REG_TOP;
            mult1_next = '0;
        end else if (pos_i < Q_TWOTHIRDS) begin
            reg1_next  = REG_FALL;
            mult1_next = MULT_W'(Q_TWOTHIRDS - pos_i);
        end else begin
            reg1_next  = REG_BASE;
            mult1_next = '0;
        end
    end

    always_comb begin
        prod6 = 33'(prod_reg) * 33'd6;
        unique case (reg3_reg)
            REG_RISE: level_next = 17'(lo_reg) + prod6[32:16];
            REG_TOP:  level_next = 17'(hi_reg);
            REG_FALL: level_next = 17'(lo_reg) + 17'(prod_reg[PROD_W-1:16]) * 17'd6;
            default:  level_next = 17'(lo_reg);
        endcase
    end

    assign scaled_full = 41'(level_reg) * 41'(OUT_SCALE);

    always_comb begin
        if (tap_i.grey) begin
            byte_next = tap_i.level;
        end else if (scaled_reg[8]) begin
            byte_next = 8'hFF;
        end else begin
            byte_next = scaled_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            reg1_reg   <= reg1_next;
            mult1_reg  <= mult1_next;
            reg2_reg   <= reg1_reg;
            mult2_reg  <= mult1_reg;
            reg3_reg   <= reg2_reg;
            prod_reg   <= PROD_W'(levels_i.diff) * PROD_W'(mult2_reg);
            lo_reg     <= levels_i.lo;
            hi_reg     <= levels_i.hi;
            level_reg  <= level_next;
            scaled_reg <= scaled_full[40:32];
            byte_reg   <= byte_next;
        end
    end

    assign byte_o = byte_reg;

    a_grey_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        en_i && tap_i.vld && tap_i.grey |=> byte_o == $past(tap_i.level))
        else $error("grey item level not passed through");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        en_i && tap_i.vld && !tap_i.grey && scaled_reg[8] |=> byte_o == 8'hFF)
        else $error("overshoot not clipped");

endmodule

`default_nettype wire

>>> bench/hsl_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;
    import hsl2rgb_pkg::*;

    localparam longint ONE_Q    = Q_ONE;
    localparam longint THIRD_Q  = Q_THIRD;
    localparam longint SIXTH_Q  = Q_SIXTH;
    localparam longint HALF_Q   = Q_HALF;
    localparam longint TWO3_Q   = Q_TWOTHIRDS;
    localparam longint SCALE_Q  = OUT_SCALE;
    localparam int     RANDOM_PIXELS = 1850;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] light;
        int         gap;
        bit         drain;
    } hsl_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_hue = 8'd0;
    logic [7:0] s_saturation = 8'd0;
    logic [7:0] s_lightness = 8'd0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;

    hsl_item_t pending_pixels[$];
    rgb_t      expected_rgb[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    int        calm_left = 0;
    int        ready_roll;
    logic      ready_next;

    hsl_to_rgb_converter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint hue_ramp(longint t, longint lo, longint hi);
        longint d;
        d = hi - lo;
        if (t < SIXTH_Q) begin
            return lo + ((d * 6 * t) >> 16);
        end
        if (t < HALF_Q) begin
            return hi;
        end
        if (t < TWO3_Q) begin
            return lo + ((d * (TWO3_Q - t)) >> 16) * 6;
        end
        return lo;
    endfunction

    function automatic logic [7:0] level_to_byte(longint level);
        longint v;
        v = (level * SCALE_Q) >> 32;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic rgb_t predict_rgb(logic [7:0] h, logic [7:0] s, logic [7:0] l);
        longint fh, fs, fl, hi, lo, tr, tg, tb;
        rgb_t   px;
        if (s == 8'd0) begin
            px.red   = l;
            px.green = l;
            px.blue  = l;
            return px;
        end
        fh = {h, 8'h00};
        fs = {s, 8'h00};
        fl = {l, 8'h00};
        if (fl < HALF_Q) begin
            hi = (fl * (ONE_Q + fs)) >> 16;
        end else begin
            hi = (fl + fs) - ((fl * fs) >> 16);
        end
        lo = 2 * fl - hi;
        if (lo < 0) begin
            lo = 0;
        end
        if (lo > hi) begin
            lo = hi;
        end
        tr = fh + THIRD_Q;
        if (tr > ONE_Q) begin
            tr = tr - ONE_Q;
        end
        tg = fh;
        tb = fh - THIRD_Q;
        if (tb < 0) begin
            tb = tb + ONE_Q;
        end
        px.red   = level_to_byte(hue_ramp(tr, lo, hi));
        px.green = level_to_byte(hue_ramp(tg, lo, hi));
        px.blue  = level_to_byte(hue_ramp(tb, lo, hi));
        return px;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic add_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] l, int gap, bit drain);
        hsl_item_t it;
        it.hue   = h;
        it.sat   = s;
        it.light = l;
        it.gap   = gap;
        it.drain = drain;
        pending_pixels.push_back(it);
    endtask

    // record accepted items; present the next after its gap and any drain wait
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rgb.push_back(predict_rgb(s_hue, s_saturation, s_lightness));
            end
            if (!s_valid || s_ready) begin
                if (pending_pixels.size() != 0 && idle_cycles >= pending_pixels[0].gap &&
                    (!pending_pixels[0].drain || expected_rgb.size() == 0)) begin
                    s_valid      <= 1'b1;
                    s_hue        <= pending_pixels[0].hue;
                    s_saturation <= pending_pixels[0].sat;
                    s_lightness  <= pending_pixels[0].light;
                    void'(pending_pixels.pop_front());
                    idle_cycles = 0;
                end else begin
                    s_valid <= 1'b0;
                    idle_cycles++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_next = 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            ready_next = 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            ready_next = 1'b1;
            if (ready_roll < 3) begin
                calm_left = $urandom_range(50, 300);
            end else if (ready_roll < 20) begin
                stall_left = $urandom_range(0, 2);
                ready_next = 1'b0;
            end else if (ready_roll < 23) begin
                stall_left = $urandom_range(10, 30);
                ready_next = 1'b0;
            end
        end
        m_ready <= ready_next;
    end

    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rgb.size() == 0) begin
                $error("unexpected item: red %0d green %0d blue %0d", m_red, m_green, m_blue);
                mismatch_count++;
            end else begin
                want = expected_rgb.pop_front();
                if (m_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, m_red);
                    mismatch_count++;
                end
                if (m_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, m_green);
                    mismatch_count++;
                end
                if (m_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, m_blue);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [7:0] h, s, l;
        bit         quiet;
        int         roll;

        add_pixel(8'd0,   8'd0,   8'd0,   0, 1'b0);
        add_pixel(8'd255, 8'd0,   8'd255, 0, 1'b0);
        add_pixel(8'd77,  8'd0,   8'd128, 2, 1'b0);
        add_pixel(8'd0,   8'd255, 8'd128, 0, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 0, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd0,   1, 1'b0);
        add_pixel(8'd0,   8'd1,   8'd1,   0, 1'b0);
        add_pixel(8'd200, 8'd1,   8'd254, 0, 1'b0);
        add_pixel(8'd30,  8'd200, 8'd127, 0, 1'b0);
        add_pixel(8'd30,  8'd200, 8'd128, 0, 1'b0);
        for (int i = 0; i < 12; i++) begin
            case (i)
                0:  h = 8'd0;
                1:  h = 8'd42;
                2:  h = 8'd43;
                3:  h = 8'd85;
                4:  h = 8'd86;
                5:  h = 8'd127;
                6:  h = 8'd128;
                7:  h = 8'd170;
                8:  h = 8'd171;
                9:  h = 8'd213;
                10: h = 8'd214;
                default: h = 8'd255;
            endcase
            add_pixel(h, 8'd255, (i % 2 == 0) ? 8'd128 : 8'd100, i % 3, 1'b0);
        end

        quiet = 1'b0;
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 150 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            h = 8'($urandom_range(0, 255));
            s = 8'($urandom_range(0, 255));
            l = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                s = 8'd0;
            end else if (roll < 14) begin
                case ($urandom_range(0, 3))
                    0:       l = 8'd0;
                    1:       l = 8'd255;
                    2:       l = 8'd127;
                    default: l = 8'd128;
                endcase
            end else if (roll < 18) begin
                s = 8'd255;
            end
            add_pixel(h, s, l, quiet ? 0 : pick_gap(), (i % 600 == 0));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_pixels.size() != 0 || s_valid) @(posedge aclk);
        while (expected_rgb.size() != 0) @(posedge aclk);
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
